// ----- sv/dccd_pkg.sv -----
package dccd_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // Controls for the year tracker
    typedef struct packed {
        logic init;
        logic step;
    } t_year_ctl;

    localparam logic [11:0] EPOCH_YEAR     = 12'd1978;
    localparam logic [1:0]  EPOCH_MOD4     = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100   = 7'd78;
    localparam logic [8:0]  EPOCH_MOD400   = 9'd378;
    localparam logic [6:0]  MOD100_LAST    = 7'd99;
    localparam logic [8:0]  MOD400_LAST    = 9'd399;

    localparam logic [15:0] DAYS_PLAIN_YEAR = 16'd365;
    localparam logic [15:0] DAYS_LEAP_YEAR  = 16'd366;

    localparam logic [4:0]  DAYS_LONG_MONTH  = 5'd31;
    localparam logic [4:0]  DAYS_SHORT_MONTH = 5'd30;
    localparam logic [4:0]  DAYS_FEB_LEAP    = 5'd29;
    localparam logic [4:0]  DAYS_FEB_PLAIN   = 5'd28;

    localparam logic [3:0]  MON_JAN = 4'd1;
    localparam logic [3:0]  MON_FEB = 4'd2;
    localparam logic [3:0]  MON_APR = 4'd4;
    localparam logic [3:0]  MON_JUN = 4'd6;
    localparam logic [3:0]  MON_SEP = 4'd9;
    localparam logic [3:0]  MON_NOV = 4'd11;
    localparam logic [3:0]  MON_DEC = 4'd12;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_SHORT_MONTH;
            MON_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB_PLAIN;
            default: len = DAYS_LONG_MONTH;
        endcase
        return len;
    endfunction

endpackage

// ----- sv/dccd_sub.sv -----
module dccd_sub (
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_diff,
    output logic        o_gt
);

    logic [16:0] w_diff;

    // one subtractor serves both the compare and the update
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_diff[15:0];
    assign o_gt   = ~w_diff[16] & (w_diff[15:0] != 16'd0);

endmodule

// ----- sv/dccd_year.sv -----
module dccd_year (
    input  logic                 i_clk,
    input  dccd_pkg::t_year_ctl  i_ctl,
    output logic [11:0]          o_year,
    output logic                 o_leap
);

    import dccd_pkg::*;

    logic [11:0] r_year;
    logic [1:0]  r_mod4;
    logic [6:0]  r_mod100;
    logic [8:0]  r_mod400;

    // residues are carried along with the year, so no divider is needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_year   <= EPOCH_YEAR;
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
        end else if (i_ctl.step) begin
            r_year   <= r_year + 12'd1;
            r_mod4   <= r_mod4 + 2'd1;
            r_mod100 <= (r_mod100 == MOD100_LAST) ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == MOD400_LAST) ? 9'd0 : r_mod400 + 9'd1;
        end
    end

    assign o_year = r_year;
    assign o_leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);

endmodule

// ----- sv/day_count_to_calendar_date.sv -----
// Channel   Direction  Handshake         Payload
// request   in         i_valid/o_stall   i_day_count
// result    out        o_valid/i_stall   o_day_of_month, o_month_number, o_year_number
//
// One request at a time. A shared 16-bit subtract/compare unit removes one year
// per cycle, then one month per cycle.
// o_stall is high from acceptance until the result has been taken.
// Synchronous active-low reset returns the sequencer to idle.
module day_count_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_day_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_number,
    output logic [11:0] o_year_number
);

    import dccd_pkg::*;

    t_state      r_state, n_state;
    logic [15:0] r_rem, n_rem;
    logic [3:0]  r_mon, n_mon;
    t_year_ctl   year_ctl;
    logic [11:0] year;
    logic        leap;
    logic [15:0] sub_b;
    logic [15:0] sub_diff;
    logic        sub_gt;

    dccd_year u_year (
        .i_clk  (i_clk),
        .i_ctl  (year_ctl),
        .o_year (year),
        .o_leap (leap)
    );

    dccd_sub u_sub (
        .i_a    (r_rem),
        .i_b    (sub_b),
        .o_diff (sub_diff),
        .o_gt   (sub_gt)
    );

    always_comb begin
        if (r_state == S_MONTH) begin
            sub_b = {11'd0, month_len(r_mon, leap)};
        end else begin
            sub_b = leap ? DAYS_LEAP_YEAR : DAYS_PLAIN_YEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_mon <= n_mon;
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_mon    = r_mon;
        year_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rem         = i_day_count;
                    n_mon         = MON_JAN;
                    year_ctl.init = 1'b1;
                    n_state       = S_YEAR;
                end
            end
            // a leap year keeps a remainder of exactly 366 as 31 December
            S_YEAR: begin
                if (sub_gt) begin
                    n_rem         = sub_diff;
                    year_ctl.step = 1'b1;
                end else begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if ((r_mon != MON_DEC) && sub_gt) begin
                    n_rem = sub_diff;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_day_of_month = r_rem[4:0];
    assign o_month_number = r_mon;
    assign o_year_number  = year;

`ifndef ASSERT_OFF
    a_mon_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH || r_state == S_DONE) |-> (r_mon >= MON_JAN && r_mon <= MON_DEC))
        else $error("month out of range");

    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rem <= 16'd31))
        else $error("day remainder too large at result");

    a_year_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> (year <= 12'd2157))
        else $error("year ran past the range of a 16-bit count");

    a_day_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_rem == 16'd0) |-> (r_mon == MON_JAN && year == EPOCH_YEAR))
        else $error("day zero outside the epoch month");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> (!o_valid && !o_stall))
        else $error("result not released after handoff");
`endif

endmodule
